[hw/rtl/bmpw_pkg.sv]
// Shared constants, queue entry type and helpers for the BMP writer.
// No dependencies; compile first.
package bmpw_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;
    localparam int CNT_W         = $clog2(MAX_DIMENSION);
    localparam int STRIDE_W      = $clog2(3 * MAX_DIMENSION + 4);
    localparam int PIX_W         = 8;
    localparam int ADDR_W        = 26;
    localparam int DATA_W        = 32;
    localparam int BYTES_W       = 3;

    localparam int HDR_BYTES      = 54;
    localparam int INFO_BYTES     = 40;
    localparam int PELS_PER_METRE = 2835;
    localparam int BITS_PER_PIXEL = 24;
    localparam int COLOUR_PLANES  = 1;
    localparam logic [7:0] SIG_B  = 8'h42;
    localparam logic [7:0] SIG_M  = 8'h4D;

    localparam int HDR_WORDS      = 14;
    localparam int STEP_W         = $clog2(HDR_WORDS + 2);
    localparam logic [STEP_W-1:0] STEP_PIXEL = STEP_W'(HDR_WORDS);
    localparam logic [STEP_W-1:0] STEP_PAD   = STEP_W'(HDR_WORDS + 1);
    localparam logic [STEP_W-1:0] STEP_HDR_LAST = STEP_W'(HDR_WORDS - 1);
    localparam int WORD_BYTES     = 4;
    localparam int PIX_BYTES      = 3;
    localparam int HDR_LAST_BYTES = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                hdr;
        logic                has_pad;
        logic                frame_end;
        logic [ADDR_W-1:0]   pix_addr;
        logic [3*PIX_W-1:0]  pix_data;
        logic [ADDR_W-1:0]   pad_addr;
        logic [1:0]          pad_bytes;
        logic [ADDR_W-1:0]   fsize;
        logic [ADDR_W-1:0]   img;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } t_job;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] c;
        c = v;
        if (v == '0) begin
            c = DIM_W'(1);
        end else if (int'(v) > MAX_DIMENSION) begin
            c = DIM_W'(MAX_DIMENSION);
        end
        return c;
    endfunction

endpackage

[hw/rtl/bmpw_ifs.sv]
// Pixel and write channel interfaces of the BMP writer.
// Depends on bmpw_pkg.
interface bmpw_pix_if;
    import bmpw_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_value;
    logic [PIX_W-1:0] green_value;
    logic [PIX_W-1:0] blue_value;

    modport source (output valid, output red_value, output green_value,
                    output blue_value, input ready);
    modport sink (input valid, input red_value, input green_value,
                  input blue_value, output ready);
endinterface

interface bmpw_wr_if;
    import bmpw_pkg::*;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  write_address;
    logic [DATA_W-1:0]  write_data;
    logic [BYTES_W-1:0] write_bytes;
    logic               last_of_run;
    logic               frame_done;
    logic [ADDR_W-1:0]  file_size_bytes;

    modport source (output valid, output write_address, output write_data,
                    output write_bytes, output last_of_run, output frame_done,
                    output file_size_bytes, input ready);
    modport sink (input valid, input write_address, input write_data,
                  input write_bytes, input last_of_run, input frame_done,
                  input file_size_bytes, output ready);
endinterface

[hw/rtl/bmpw_front.sv]
// Front end: accepts pixels, tracks raster position and works out addresses.
// Depends on bmpw_pkg and bmpw_pix_if.
module bmpw_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bmpw_pix_if.sink                    i_pix,
    input  logic [bmpw_pkg::DIM_W-1:0]  i_frame_width,
    input  logic [bmpw_pkg::DIM_W-1:0]  i_frame_height,
    input  logic                        i_full,
    output logic                        o_push,
    output bmpw_pkg::t_job              o_job
);
    import bmpw_pkg::*;

    logic [DIM_W-1:0]  w, h, w_m1, h_m1;
    logic [CNT_W-1:0]  col, row, n_col, n_row;
    logic              row_end, frame_end, n_hdr_done;
    logic              accept, en1, en2;

    logic [CNT_W-1:0]  r_col, r_row;
    logic              r_hdr_done;

    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_red, r_s1_green, r_s1_blue;
    logic [CNT_W-1:0]  r_s1_col, r_s1_rows_below;
    logic [DIM_W-1:0]  r_s1_w, r_s1_h;
    logic              r_s1_hdr, r_s1_row_end, r_s1_frame_end;

    logic [STRIDE_W-1:0]       s1_w3, s1_stride, s1_col3;
    logic [STRIDE_W+DIM_W-1:0] s1_img;
    logic [STRIDE_W+CNT_W-1:0] s1_off;

    logic                r_s2_valid;
    logic [3*PIX_W-1:0]  r_s2_pix;
    logic [STRIDE_W-1:0] r_s2_col3, r_s2_w3;
    logic [ADDR_W-1:0]   r_s2_off, r_s2_img;
    logic                r_s2_hdr, r_s2_has_pad, r_s2_frame_end;
    logic [1:0]          r_s2_pad;
    logic [DIM_W-1:0]    r_s2_w, r_s2_h;

    logic [ADDR_W-1:0]   row_base;

    assign w    = clamp_dim(i_frame_width);
    assign h    = clamp_dim(i_frame_height);
    assign w_m1 = w - DIM_W'(1);
    assign h_m1 = h - DIM_W'(1);

    assign col = (DIM_W'(r_col) >= w) ? CNT_W'(w_m1) : r_col;
    assign row = (DIM_W'(r_row) >= h) ? CNT_W'(h_m1) : r_row;
    assign row_end   = (DIM_W'(col) == w_m1);
    assign frame_end = row_end && (DIM_W'(row) == h_m1);

    assign n_col      = row_end ? '0 : col + CNT_W'(1);
    assign n_row      = frame_end ? '0 : (row_end ? row + CNT_W'(1) : row);
    assign n_hdr_done = !frame_end;

    assign en2         = !r_s2_valid || !i_full;
    assign en1         = !r_s1_valid || en2;
    assign i_pix.ready = en1;
    assign accept      = i_pix.valid && en1;
    assign o_push      = r_s2_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_hdr_done <= 1'b0;
        end else if (accept) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_hdr_done <= n_hdr_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= i_pix.valid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_red        <= i_pix.red_value;
            r_s1_green      <= i_pix.green_value;
            r_s1_blue       <= i_pix.blue_value;
            r_s1_col        <= col;
            r_s1_rows_below <= CNT_W'(h_m1 - DIM_W'(row));
            r_s1_w          <= w;
            r_s1_h          <= h;
            r_s1_hdr        <= !r_hdr_done;
            r_s1_row_end    <= row_end;
            r_s1_frame_end  <= frame_end;
        end
    end

    assign s1_w3     = STRIDE_W'({r_s1_w, 1'b0}) + STRIDE_W'(r_s1_w);
    assign s1_stride = s1_w3 + STRIDE_W'(r_s1_w[1:0]);
    assign s1_col3   = STRIDE_W'({r_s1_col, 1'b0}) + STRIDE_W'(r_s1_col);
    assign s1_img    = s1_stride * r_s1_h;
    assign s1_off    = s1_stride * r_s1_rows_below;

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_valid) begin
            r_s2_pix       <= {r_s1_red, r_s1_green, r_s1_blue};
            r_s2_col3      <= s1_col3;
            r_s2_w3        <= s1_w3;
            r_s2_off       <= ADDR_W'(s1_off);
            r_s2_img       <= ADDR_W'(s1_img);
            r_s2_hdr       <= r_s1_hdr;
            r_s2_has_pad   <= r_s1_row_end && (r_s1_w[1:0] != 2'b00);
            r_s2_pad       <= r_s1_w[1:0];
            r_s2_frame_end <= r_s1_frame_end;
            r_s2_w         <= r_s1_w;
            r_s2_h         <= r_s1_h;
        end
    end

    assign row_base = ADDR_W'(HDR_BYTES) + r_s2_off;

    always_comb begin
        o_job.hdr       = r_s2_hdr;
        o_job.has_pad   = r_s2_has_pad;
        o_job.frame_end = r_s2_frame_end;
        o_job.pix_addr  = row_base + ADDR_W'(r_s2_col3);
        o_job.pix_data  = r_s2_pix;
        o_job.pad_addr  = row_base + ADDR_W'(r_s2_w3);
        o_job.pad_bytes = r_s2_pad;
        o_job.fsize     = ADDR_W'(HDR_BYTES) + r_s2_img;
        o_job.img       = r_s2_img;
        o_job.width     = r_s2_w;
        o_job.height    = r_s2_h;
    end

endmodule

[hw/rtl/bmpw_queue.sv]
// Short job queue between front end and write sequencer.
// Depends on bmpw_pkg.
module bmpw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmpw_pkg::t_job i_job,
    input  logic           i_pop,
    output bmpw_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);
    import bmpw_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

[hw/rtl/bmpw_back.sv]
// Write sequencer: expands each job into header, pixel and padding words.
// Depends on bmpw_pkg and bmpw_wr_if.
module bmpw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bmpw_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    bmpw_wr_if.source      o_wr
);
    import bmpw_pkg::*;

    function automatic logic [DATA_W-1:0] hdr_word(input logic [STEP_W-1:0] idx,
                                                   input t_job j);
        logic [DATA_W-1:0] d;
        logic [15:0]       fs_lo, fs_hi, im_lo, im_hi;
        fs_lo = j.fsize[15:0];
        fs_hi = 16'(j.fsize[ADDR_W-1:16]);
        im_lo = j.img[15:0];
        im_hi = 16'(j.img[ADDR_W-1:16]);
        case (idx)
            STEP_W'(0):  d = {fs_lo, SIG_M, SIG_B};
            STEP_W'(1):  d = {16'h0, fs_hi};
            STEP_W'(2):  d = {16'(HDR_BYTES), 16'h0};
            STEP_W'(3):  d = {16'(INFO_BYTES), 16'h0};
            STEP_W'(4):  d = {16'(j.width), 16'h0};
            STEP_W'(5):  d = {16'(j.height), 16'h0};
            STEP_W'(6):  d = {16'(COLOUR_PLANES), 16'h0};
            STEP_W'(7):  d = {16'h0, 16'(BITS_PER_PIXEL)};
            STEP_W'(8):  d = {im_lo, 16'h0};
            STEP_W'(9):  d = {16'(PELS_PER_METRE), im_hi};
            STEP_W'(10): d = {16'(PELS_PER_METRE), 16'h0};
            default:     d = '0;
        endcase
        return d;
    endfunction

    logic [STEP_W-1:0]  r_step;
    logic               r_started;
    logic [STEP_W-1:0]  step;
    logic               load, final_word;

    logic               r_valid;
    logic [ADDR_W-1:0]  r_addr, r_size;
    logic [DATA_W-1:0]  r_data;
    logic [BYTES_W-1:0] r_bytes;
    logic               r_last, r_done;

    logic [ADDR_W-1:0]  n_addr, n_size;
    logic [DATA_W-1:0]  n_data;
    logic [BYTES_W-1:0] n_bytes;
    logic               n_last, n_done;

    assign step       = r_started ? r_step : (i_job.hdr ? '0 : STEP_PIXEL);
    assign load       = !i_empty && (!r_valid || o_wr.ready);
    assign final_word = (step == STEP_PAD) || ((step == STEP_PIXEL) && !i_job.has_pad);
    assign o_pop      = load && final_word;

    always_comb begin
        case (step)
            STEP_PIXEL: begin
                n_addr  = i_job.pix_addr;
                n_data  = DATA_W'(i_job.pix_data);
                n_bytes = BYTES_W'(PIX_BYTES);
                n_last  = !i_job.has_pad;
                n_done  = !i_job.has_pad && i_job.frame_end;
                n_size  = n_done ? i_job.fsize : '0;
            end
            STEP_PAD: begin
                n_addr  = i_job.pad_addr;
                n_data  = '0;
                n_bytes = BYTES_W'(i_job.pad_bytes);
                n_last  = 1'b1;
                n_done  = i_job.frame_end;
                n_size  = i_job.frame_end ? i_job.fsize : '0;
            end
            default: begin
                n_addr  = ADDR_W'({step, 2'b00});
                n_data  = hdr_word(step, i_job);
                n_bytes = (step == STEP_HDR_LAST) ? BYTES_W'(HDR_LAST_BYTES)
                                                  : BYTES_W'(WORD_BYTES);
                n_last  = 1'b0;
                n_done  = 1'b0;
                n_size  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_started <= 1'b0;
            r_step    <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_wr.ready) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                r_started <= !final_word;
                r_step    <= step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_bytes <= n_bytes;
            r_last  <= n_last;
            r_done  <= n_done;
            r_size  <= n_size;
        end
    end

    assign o_wr.valid           = r_valid;
    assign o_wr.write_address   = r_addr;
    assign o_wr.write_data      = r_data;
    assign o_wr.write_bytes     = r_bytes;
    assign o_wr.last_of_run     = r_last;
    assign o_wr.frame_done      = r_done;
    assign o_wr.file_size_bytes = r_size;

endmodule

[hw/rtl/rgb888_to_bmp_writer_unit.sv]
// The first write of a pixel passes through the front-end stage registers, the job queue and the output register.
// Throughput: one pixel per cycle while the job queue has room; one write per cycle leaves
// while the port is ready, so a pixel costs one write, two at a padded row end, plus 14 header writes at frame start.
// The output write port sets the rate; a 4-entry job queue absorbs output stalls.
// Reset (synchronous, active low) empties pipeline and queue, zeroes the raster
// counters, rearms the header and loads 640 x 480 into the size registers.
module rgb888_to_bmp_writer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bmpw_pix_if.sink                      i_pix,
    bmpw_wr_if.source                     o_wr,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpw_pkg::PADDR_W-1:0]  paddr,
    input  logic [bmpw_pkg::PDATA_W-1:0]  pwdata,
    output logic [bmpw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import bmpw_pkg::*;

    logic [DIM_W-1:0] r_frame_width, r_frame_height;
    logic             cfg_wr, push, pop, full, empty;
    t_job             front_job, head_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(RESET_WIDTH);
            r_frame_height <= DIM_W'(RESET_HEIGHT);
        end else if (cfg_wr) begin
            case (paddr[PADDR_W-1])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1])
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    bmpw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (i_pix),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_full         (full),
        .o_push         (push),
        .o_job          (front_job)
    );

    bmpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    bmpw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_wr    (o_wr)
    );

endmodule

[hw/rtl/bmpw_checker.sv]
// Port-level checks on the write channel of the BMP writer, bound to the top level.
// Depends on bmpw_pkg and rgb888_to_bmp_writer_unit.
module bmpw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_wr_valid,
    input logic                           i_wr_ready,
    input logic [bmpw_pkg::ADDR_W-1:0]    i_wr_address,
    input logic [bmpw_pkg::DATA_W-1:0]    i_wr_data,
    input logic [bmpw_pkg::BYTES_W-1:0]   i_wr_bytes,
    input logic                           i_wr_last,
    input logic                           i_wr_done,
    input logic [bmpw_pkg::ADDR_W-1:0]    i_wr_size
);
    import bmpw_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_wr_valid)
        else $error("write valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid && !i_wr_ready |=>
            i_wr_valid && $stable(i_wr_address) && $stable(i_wr_data))
        else $error("stalled write changed");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid && i_wr_done |-> i_wr_last)
        else $error("frame end not on last write of pixel");

    a_size_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid && !i_wr_done |-> i_wr_size == '0)
        else $error("file size outside frame end");

    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid |-> (i_wr_bytes != '0) && (i_wr_bytes <= BYTES_W'(WORD_BYTES)))
        else $error("byte count out of range");

endmodule

bind rgb888_to_bmp_writer_unit bmpw_checker u_bmpw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_wr_valid   (o_wr.valid),
    .i_wr_ready   (o_wr.ready),
    .i_wr_address (o_wr.write_address),
    .i_wr_data    (o_wr.write_data),
    .i_wr_bytes   (o_wr.write_bytes),
    .i_wr_last    (o_wr.last_of_run),
    .i_wr_done    (o_wr.frame_done),
    .i_wr_size    (o_wr.file_size_bytes)
);
